/* hdl/quadrature_odometer_speed_top_macros.svh */
// ---------------------------------------------------------------------------
// Quadrature odometer assertion macros
// Shared property wrappers for the odometer checks.
// ---------------------------------------------------------------------------
`ifndef QUADRATURE_ODOMETER_SPEED_TOP_MACROS_SVH
`define QUADRATURE_ODOMETER_SPEED_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk and quiet during reset.
`define QOS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and quiet during reset.
`define QOS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/qos_pkg.sv */
// ---------------------------------------------------------------------------
// Quadrature odometer package
// Shared constants, register indexes, controller codes and handshake structs.
// ---------------------------------------------------------------------------
package qos_pkg;

  localparam int NUM_W     = 16;
  localparam int TOTAL_W   = 48;
  localparam int NUM_SHIFT = TOTAL_W - NUM_W;
  localparam int STEP_W    = 6;

  localparam logic [STEP_W-1:0] NUM_STEPS   = STEP_W'(NUM_W);
  localparam logic [STEP_W-1:0] TOTAL_STEPS = STEP_W'(TOTAL_W);

  localparam logic [NUM_W-1:0] NUM_RESET     = 16'd100;
  localparam logic [NUM_W-1:0] TIMEOUT_RESET = 16'd1000;

  localparam logic REG_SPEED_NUM = 1'b0;
  localparam logic REG_TIMEOUT   = 1'b1;

  localparam logic FUNC_EDGE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [1:0] DIR_UNKNOWN  = 2'd0;
  localparam logic [1:0] DIR_FORWARD  = 2'd1;
  localparam logic [1:0] DIR_BACKWARD = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV1 = 5'b00010,
    S_UPD  = 5'b00100,
    S_DIV2 = 5'b01000,
    S_PUB  = 5'b10000
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_mean;
    logic speed_update;
    logic mean_update;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic needs_speed;
    logic div_busy;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

/* hdl/quadrature_odometer_speed_top.sv */
// ---------------------------------------------------------------------------
// Quadrature odometer with period speed
// A tick, or an edge within the same millisecond, goes on to the publish state
// once accepted. An edge that measures speed first runs the shared serial
// divider twice (16 steps for speed, 48 for the mean). One item is in work at
// a time; the result register frees the output side. Synchronous reset clears
// control and odometry state, loads register defaults, leaves result fields.
// ---------------------------------------------------------------------------
`include "quadrature_odometer_speed_top_macros.svh"

module quadrature_odometer_speed_top import qos_pkg::*; #(
  parameter int COUNT_WIDTH = 32,
  parameter int SPEED_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic               channel,
  input  logic               rising,
  input  logic               other_level,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] position,
  output logic [31:0]        edge_count,
  output logic signed [16:0] current_speed,
  output logic [15:0]        average_speed,
  output logic [15:0]        highest_speed,
  output logic [1:0]         direction
);

  cmd_t  cmd;
  stat_t stat;

  qos_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  qos_dp #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .SPEED_WIDTH (SPEED_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .func          (func),
    .channel       (channel),
    .rising        (rising),
    .other_level   (other_level),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .position      (position),
    .edge_count    (edge_count),
    .current_speed (current_speed),
    .average_speed (average_speed),
    .highest_speed (highest_speed),
    .direction     (direction)
  );

  `QOS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted beat did not close intake")
  `QOS_ASSERT_NOW(a_publish_free, cmd.publish, stat.out_free, "result overwritten before it was taken")
  `QOS_ASSERT_NOW(a_div_idle_start, cmd.div_start, !stat.div_busy, "divider restarted while busy")
  `QOS_ASSERT_NOW(a_valid_from_publish, $rose(out_valid), $past(cmd.publish), "result beat without publish")

endmodule

/* hdl/qos_div.sv */
// ---------------------------------------------------------------------------
// Quadrature odometer serial divider
// Restoring divider, one quotient bit per cycle, step count set at start.
// ---------------------------------------------------------------------------
module qos_div import qos_pkg::*; #(
  parameter int DIVISOR_W = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [STEP_W-1:0]    steps,
  input  logic [TOTAL_W-1:0]   dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 busy,
  output logic                 done,
  output logic [TOTAL_W-1:0]   quotient
);

  logic [DIVISOR_W-1:0] rem;
  logic [STEP_W-1:0]    cnt;
  logic [DIVISOR_W:0]   rem_sh;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;
  logic [DIVISOR_W-1:0] rem_next;

  // The dividend is left-aligned by the caller, so the quotient bits shift in
  // at the bottom while the unused low dividend bits move up as zeros.
  always_comb begin
    rem_sh   = {rem, quotient[TOTAL_W-1]};
    diff     = rem_sh - {1'b0, divisor};
    fits     = rem_sh >= {1'b0, divisor};
    rem_next = fits ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == STEP_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[TOTAL_W-2:0], fits};
      rem      <= rem_next;
    end
  end

endmodule

/* hdl/qos_dp.sv */
// ---------------------------------------------------------------------------
// Quadrature odometer datapath
// Odometry state, speed statistics, shared divider and the result register.
// ---------------------------------------------------------------------------
module qos_dp import qos_pkg::*; #(
  parameter int COUNT_WIDTH = 32,
  parameter int SPEED_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [NUM_W-1:0]   cfg_data,
  input  logic               func,
  input  logic               channel,
  input  logic               rising,
  input  logic               other_level,
  input  logic               out_stall,
  output logic               out_valid,
  output logic signed [31:0] position,
  output logic [31:0]        edge_count,
  output logic signed [16:0] current_speed,
  output logic [15:0]        average_speed,
  output logic [15:0]        highest_speed,
  output logic [1:0]         direction
);

  localparam int DIVISOR_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
  localparam logic [TOTAL_W-1:0] SPEED_MAX =
    (TOTAL_W'(1) << SPEED_WIDTH) - TOTAL_W'(1);

  logic [NUM_W-1:0]       speed_num;
  logic [NUM_W-1:0]       timeout_ms;
  logic [31:0]            time_ms;
  logic [31:0]            last_edge;
  logic [15:0]            idle_count;
  logic                   armed;
  logic [COUNT_WIDTH-1:0] net_pos;
  logic [COUNT_WIDTH-1:0] total_edges;
  logic [SPEED_WIDTH-1:0] speed_now;
  logic [SPEED_WIDTH-1:0] speed_before;
  logic [SPEED_WIDTH-1:0] speed_peak;
  logic [TOTAL_W-1:0]     speed_total;
  logic [SPEED_WIDTH-1:0] speed_mean;
  logic [1:0]             heading;

  logic                   div_busy;
  logic                   div_done;
  logic [TOTAL_W-1:0]     quotient;
  logic [TOTAL_W-1:0]     dividend;
  logic [DIVISOR_W-1:0]   divisor;
  logic [STEP_W-1:0]      steps;

  logic                   forward;
  logic [15:0]            idle_next;
  logic [SPEED_WIDTH-1:0] speed_sat;
  logic [SPEED_WIDTH:0]   pair_sum;
  logic [SPEED_WIDTH-1:0] pair;
  logic [TOTAL_W:0]       total_sum;
  logic [16:0]            now17;

  // Speed is the numerator over elapsed milliseconds; the mean is the speed
  // sum over the edge count. Both run through the same divider.
  always_comb begin
    if (cmd.div_mean) begin
      dividend = speed_total;
      divisor  = (total_edges == '0) ? DIVISOR_W'(1) : DIVISOR_W'(total_edges);
      steps    = TOTAL_STEPS;
    end else begin
      dividend = TOTAL_W'(speed_num) << NUM_SHIFT;
      // Elapsed time wraps at 32 bits before it is widened.
      divisor  = DIVISOR_W'(32'(time_ms - last_edge));
      steps    = NUM_STEPS;
    end
  end

  qos_div #(
    .DIVISOR_W(DIVISOR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .steps    (steps),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    forward   = channel ? (rising != other_level) : (rising == other_level);
    idle_next = (idle_count == 16'hFFFF) ? idle_count : idle_count + 16'd1;
    speed_sat = (quotient > SPEED_MAX) ? SPEED_MAX[SPEED_WIDTH-1:0]
                                       : quotient[SPEED_WIDTH-1:0];
    pair_sum  = {1'b0, speed_before} + {1'b0, speed_sat};
    pair      = pair_sum[SPEED_WIDTH:1];
    total_sum = {1'b0, speed_total} + (TOTAL_W + 1)'(speed_sat);
    now17     = 17'(speed_now);
  end

  always_comb begin
    stat.needs_speed = time_ms != last_edge;
    stat.div_busy    = div_busy;
    stat.div_done    = div_done;
    stat.out_free    = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_num    <= NUM_RESET;
      timeout_ms   <= TIMEOUT_RESET;
      time_ms      <= '0;
      last_edge    <= '0;
      idle_count   <= '0;
      armed        <= 1'b1;
      net_pos      <= '0;
      total_edges  <= '0;
      speed_now    <= '0;
      speed_before <= '0;
      speed_peak   <= '0;
      speed_total  <= '0;
      speed_mean   <= '0;
      heading      <= DIR_UNKNOWN;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SPEED_NUM: speed_num  <= cfg_data;
          REG_TIMEOUT:   timeout_ms <= cfg_data;
          default:       ;
        endcase
      end
      if (cmd.accept) begin
        if (func == FUNC_TICK) begin
          time_ms <= time_ms + 32'd1;
          if (armed) begin
            idle_count <= idle_next;
            if (idle_next >= timeout_ms) begin
              speed_now <= '0;
              armed     <= 1'b0;
            end
          end
        end else begin
          heading <= forward ? DIR_FORWARD : DIR_BACKWARD;
          net_pos <= forward ? net_pos + COUNT_WIDTH'(1) : net_pos - COUNT_WIDTH'(1);
          if (total_edges != '1) begin
            total_edges <= total_edges + COUNT_WIDTH'(1);
          end
        end
      end
      if (cmd.speed_update) begin
        if (pair > speed_peak) begin
          speed_peak <= pair;
        end
        speed_total  <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
        speed_now    <= speed_sat;
        speed_before <= speed_sat;
        last_edge    <= time_ms;
        idle_count   <= '0;
        armed        <= 1'b1;
      end
      if (cmd.mean_update) begin
        speed_mean <= speed_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      position      <= 32'(net_pos);
      edge_count    <= 32'(total_edges);
      current_speed <= (heading == DIR_BACKWARD) ? 17'd0 - now17 : now17;
      average_speed <= 16'(speed_mean);
      highest_speed <= 16'(speed_peak);
      direction     <= heading;
    end
  end

endmodule

/* hdl/qos_ctrl.sv */
// ---------------------------------------------------------------------------
// Quadrature odometer controller
// Sequences item intake, the two divisions and the result publish.
// ---------------------------------------------------------------------------
module qos_ctrl import qos_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  func,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  in_stall
);

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          // An edge in a new millisecond measures speed; the time registers
          // are not touched by an edge, so the check is valid right now.
          if (func == FUNC_EDGE && stat.needs_speed) begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV1;
          end else begin
            state_next = S_PUB;
          end
        end
      end
      S_DIV1: begin
        if (stat.div_done) begin
          cmd.speed_update = 1'b1;
          state_next       = S_UPD;
        end
      end
      S_UPD: begin
        cmd.div_start = 1'b1;
        cmd.div_mean  = 1'b1;
        state_next    = S_DIV2;
      end
      S_DIV2: begin
        // The divider reads its divisor on every step, so the mean operands
        // stay selected for the whole division.
        cmd.div_mean = 1'b1;
        if (stat.div_done) begin
          cmd.mean_update = 1'b1;
          state_next      = S_PUB;
        end
      end
      S_PUB: begin
        if (stat.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

/* bench/tb_top.sv */
// ---------------------------------------------------------------------------
// Quadrature odometer testbench
// Drives edge and tick beats through the valid/stall input channel and
// checks every reading beat against an in-bench odometer predictor.
// Directed cases come first, then phases of random quadrature motion and noise.
// ---------------------------------------------------------------------------
module tb_top;
  import qos_pkg::*;

  typedef struct packed {
    logic signed [31:0] position;
    logic [31:0]        edges;
    logic signed [16:0] speed;
    logic [15:0]        mean;
    logic [15:0]        peak;
    logic [1:0]         dir;
  } odo_reading_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_index = REG_SPEED_NUM;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic func = FUNC_TICK;
  logic channel = 1'b0;
  logic rising = 1'b0;
  logic other_level = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] position;
  logic [31:0] edge_count;
  logic signed [16:0] current_speed;
  logic [15:0] average_speed;
  logic [15:0] highest_speed;
  logic [1:0] direction;

  quadrature_odometer_speed_top u_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .channel(channel), .rising(rising), .other_level(other_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .position(position), .edge_count(edge_count), .current_speed(current_speed),
    .average_speed(average_speed), .highest_speed(highest_speed),
    .direction(direction)
  );

  // Predictor state and configuration.
  logic [15:0] pulse_num;
  logic [15:0] idle_limit;
  logic [31:0] ms_clock;
  logic [31:0] last_speed_ms;
  logic [15:0] idle_ms;
  logic        clear_armed;
  logic [31:0] pos_acc;
  logic [31:0] edges_acc;
  logic [15:0] spd_now;
  logic [15:0] spd_prev;
  logic [15:0] spd_peak;
  logic [47:0] spd_sum;
  logic [15:0] spd_mean;
  logic [1:0]  heading;

  odo_reading_t pending_readings[$];
  int errors = 0;
  int beats_sent = 0;
  bit in_gaps = 1'b1;
  bit out_gaps = 1'b1;
  int stall_left = 0;
  logic a_lvl = 1'b0;
  logic b_lvl = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[quadrature_odometer_speed_top] ERROR");
    $finish;
  end

  function automatic logic [15:0] clamp_speed(input logic [63:0] v);
    return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  task automatic predict_reading(input logic f, input logic ch, input logic ri,
                                 input logic ol);
    odo_reading_t r;
    logic fwd;
    logic [63:0] elapsed;
    logic [15:0] spd;
    logic [63:0] pair;
    logic [63:0] sum;
    if (f == FUNC_TICK) begin
      ms_clock = ms_clock + 32'd1;
      if (clear_armed) begin
        if (idle_ms != 16'hFFFF) idle_ms = idle_ms + 16'd1;
        if (idle_ms >= idle_limit) begin
          spd_now = '0;
          clear_armed = 1'b0;
        end
      end
    end else begin
      fwd = ch ? (ri != ol) : (ri == ol);
      heading = fwd ? DIR_FORWARD : DIR_BACKWARD;
      pos_acc = fwd ? pos_acc + 32'd1 : pos_acc - 32'd1;
      if (edges_acc != 32'hFFFF_FFFF) edges_acc = edges_acc + 32'd1;
      // No speed is measured within the millisecond of the last timed edge.
      if (ms_clock != last_speed_ms) begin
        elapsed = 64'(ms_clock - last_speed_ms);
        spd = clamp_speed(64'(pulse_num) / elapsed);
        pair = (64'(spd_prev) + 64'(spd)) >> 1;
        if (pair > 64'(spd_peak)) spd_peak = clamp_speed(pair);
        sum = 64'(spd_sum) + 64'(spd);
        spd_sum = (sum > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : sum[47:0];
        spd_mean = clamp_speed(64'(spd_sum) / 64'(edges_acc));
        spd_now = spd;
        spd_prev = spd;
        last_speed_ms = ms_clock;
        idle_ms = '0;
        clear_armed = 1'b1;
      end
    end
    r.position = pos_acc;
    r.edges = edges_acc;
    r.speed = (heading == DIR_BACKWARD) ? 17'd0 - {1'b0, spd_now} : {1'b0, spd_now};
    r.mean = spd_mean;
    r.peak = spd_peak;
    r.dir = heading;
    pending_readings.push_back(r);
  endtask

  task automatic compare_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      $display("%0t %s: expected %h, got %h", $time, name, exp_v, got_v);
    end
  endtask

  // Output side: checks each reading beat and stalls at random between beats.
  always @(posedge clk) begin
    odo_reading_t e;
    if (rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_readings.size() == 0) begin
          errors++;
          $display("%0t unexpected reading beat: expected none, got position %0d",
                   $time, position);
        end else begin
          e = pending_readings.pop_front();
          compare_field("position", e.position, position);
          compare_field("edge_count", e.edges, edge_count);
          compare_field("current_speed", e.speed, current_speed);
          compare_field("average_speed", e.mean, average_speed);
          compare_field("highest_speed", e.peak, highest_speed);
          compare_field("direction", e.dir, direction);
        end
        stall_left = out_gaps ? $urandom_range(0, 3) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  task automatic send_beat(input logic f, input logic ch, input logic ri,
                           input logic ol);
    int gap;
    gap = in_gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    channel <= ch;
    rising <= ri;
    other_level <= ol;
    do @(posedge clk); while (in_stall);
    predict_reading(f, ch, ri, ol);
    beats_sent++;
  endtask

  task automatic send_tick();
    send_beat(FUNC_TICK, 1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // One well-formed quadrature step; forward toggles B when the levels match.
  task automatic send_step(input bit fwd);
    bit toggle_b;
    toggle_b = fwd ? (a_lvl == b_lvl) : (a_lvl != b_lvl);
    if (toggle_b) begin
      send_beat(FUNC_EDGE, 1'b1, ~b_lvl, a_lvl);
      b_lvl = ~b_lvl;
    end else begin
      send_beat(FUNC_EDGE, 1'b0, ~a_lvl, b_lvl);
      a_lvl = ~a_lvl;
    end
  endtask

  task automatic wait_for_readings();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_SPEED_NUM) pulse_num = val;
    else idle_limit = val;
  endtask

  task automatic test_reset_reading();
    send_tick();
  endtask

  // Every combination of channel, rising and other level on an edge; the first
  // one measures speed, the rest share its millisecond.
  task automatic test_direction_rule();
    for (int k = 0; k < 8; k++) send_beat(FUNC_EDGE, k[2], k[1], k[0]);
  endtask

  task automatic test_tick_ignores_fields();
    send_beat(FUNC_TICK, 1'b0, 1'b0, 1'b0);
    send_beat(FUNC_TICK, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_speed_limits();
    wait_for_readings();
    write_register(REG_SPEED_NUM, 16'hFFFF);
    write_register(REG_TIMEOUT, 16'd1);
    send_tick();
    send_step(1'b1);
    send_tick();
    send_step(1'b1);
    send_tick();
    send_step(1'b0);
    send_step(1'b0);
    send_tick();
    wait_for_readings();
    write_register(REG_SPEED_NUM, 16'd1);
    write_register(REG_TIMEOUT, 16'hFFFF);
    send_tick();
    send_tick();
    send_step(1'b1);
  endtask

  task automatic test_random_motion();
    int target;
    int run_len;
    int ticks;
    bit fwd;
    logic [15:0] num_v;
    logic [15:0] tmo_v;
    for (int phase = 0; phase < 7; phase++) begin
      wait_for_readings();
      case ($urandom_range(0, 3))
        0: num_v = 16'd1;
        1: num_v = 16'hFFFF;
        2: num_v = 16'($urandom_range(1, 300));
        default: num_v = 16'($urandom_range(1, 65535));
      endcase
      case ($urandom_range(0, 3))
        0: tmo_v = 16'd1;
        1: tmo_v = 16'hFFFF;
        2: tmo_v = 16'($urandom_range(1, 8));
        default: tmo_v = 16'($urandom_range(1, 65535));
      endcase
      write_register(REG_SPEED_NUM, num_v);
      write_register(REG_TIMEOUT, tmo_v);
      target = beats_sent + 257;
      while (beats_sent < target) begin
        in_gaps = ($urandom_range(0, 3) != 0);
        out_gaps = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 9))
          7: begin
            // Dithering back and forth around one spot.
            run_len = $urandom_range(4, 12);
            for (int k = 0; k < run_len; k++) begin
              if ($urandom_range(0, 1)) send_tick();
              send_step(k[0]);
            end
          end
          8, 9: begin
            run_len = $urandom_range(5, 15);
            for (int k = 0; k < run_len; k++)
              send_beat(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
          end
          default: begin
            fwd = $urandom_range(0, 1);
            run_len = $urandom_range(4, 20);
            for (int k = 0; k < run_len; k++) begin
              ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60)
                                                   : $urandom_range(0, 2);
              repeat (ticks) send_tick();
              send_step(fwd);
            end
          end
        endcase
      end
    end
    in_gaps = 1'b1;
    out_gaps = 1'b1;
  endtask

  initial begin
    pulse_num = NUM_RESET;
    idle_limit = TIMEOUT_RESET;
    ms_clock = '0;
    last_speed_ms = '0;
    idle_ms = '0;
    clear_armed = 1'b1;
    pos_acc = '0;
    edges_acc = '0;
    spd_now = '0;
    spd_prev = '0;
    spd_peak = '0;
    spd_sum = '0;
    spd_mean = '0;
    heading = DIR_UNKNOWN;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_reading();
    test_direction_rule();
    test_tick_ignores_fields();
    test_speed_limits();
    test_random_motion();
    wait_for_readings();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("[quadrature_odometer_speed_top] OK");
    end else begin
      $display("[quadrature_odometer_speed_top] ERROR");
    end
    $finish;
  end

endmodule
